@@ hw/rtl/csmf_pkg.sv @@
package csmf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field widths
    localparam int PIXEL_FIELD_BITS = 16;
    localparam int MEAN_BITS        = 24;
    localparam int ROW_FIELD_BITS   = 12;
    localparam int COL_FIELD_BITS   = 10;
    localparam int FRAC_BITS        = 8;
    localparam int CNT_BITS         = 3;
    localparam int SUM_GROWTH       = 3;
    localparam int MAX_RESULTS      = 3;
    localparam int RES_COUNT_BITS   = 2;

    // Stream packing
    localparam int OUT_TDATA_BITS = 48;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - MEAN_BITS - ROW_FIELD_BITS - COL_FIELD_BITS;

    // Configuration registers
    localparam int CFG_ADDR_BITS      = 3;
    localparam int CFG_DATA_BITS      = 32;
    localparam int FRAME_WIDTH_BITS   = 11;
    localparam int FRAME_HEIGHT_BITS  = 13;
    localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd1024;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // Tag and divisor of one pending result
    typedef struct packed
    {
        logic [ROW_FIELD_BITS-1:0] row;
        logic [COL_FIELD_BITS-1:0] col;
        logic [CNT_BITS-1:0]       cnt;
        logic                      frame_done;
        logic                      run_last;
    } res_tag_t;

    // Rounded fraction (rem*256 + cnt/2) / cnt for a remainder below cnt
    function automatic logic [FRAC_BITS-1:0] frac_lookup(
        input logic [CNT_BITS-1:0] cnt,
        input logic [CNT_BITS-1:0] rem
    );
        logic [FRAC_BITS-1:0] f;
        f = '0;
        case (cnt)
            3'd2:
            begin
                case (rem)
                    3'd1:    f = 8'd128;
                    default: f = 8'd0;
                endcase
            end
            3'd3:
            begin
                case (rem)
                    3'd1:    f = 8'd85;
                    3'd2:    f = 8'd171;
                    default: f = 8'd0;
                endcase
            end
            3'd4:
            begin
                case (rem)
                    3'd1:    f = 8'd64;
                    3'd2:    f = 8'd128;
                    3'd3:    f = 8'd192;
                    default: f = 8'd0;
                endcase
            end
            3'd5:
            begin
                case (rem)
                    3'd1:    f = 8'd51;
                    3'd2:    f = 8'd102;
                    3'd3:    f = 8'd154;
                    3'd4:    f = 8'd205;
                    default: f = 8'd0;
                endcase
            end
            default: f = 8'd0;
        endcase
        return f;
    endfunction

endpackage

@@ hw/rtl/csmf_ram.sv @@
module csmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Reads return the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ hw/rtl/csmf_stencil.sv @@
module csmf_stencil #(
    parameter int MAX_WIDTH  = csmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csmf_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = csmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [csmf_pkg::FRAME_WIDTH_BITS-1:0]         frame_width,
    input  logic [csmf_pkg::FRAME_HEIGHT_BITS-1:0]        frame_height,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [csmf_pkg::PIXEL_FIELD_BITS-1:0]         in_pixel,
    output logic                                          grp_valid,
    input  logic                                          grp_ready,
    output logic [csmf_pkg::RES_COUNT_BITS-1:0]           grp_count,
    output csmf_pkg::res_tag_t                            grp_tag [csmf_pkg::MAX_RESULTS],
    output logic [PIXEL_BITS+csmf_pkg::SUM_GROWTH-1:0]    grp_sum [csmf_pkg::MAX_RESULTS]
);

    import csmf_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP     = (W_BITS > FRAME_WIDTH_BITS) ? W_BITS : FRAME_WIDTH_BITS;
    localparam int HCMP     = (H_BITS > FRAME_HEIGHT_BITS) ? H_BITS : FRAME_HEIGHT_BITS;
    localparam int SUM_BITS = PIXEL_BITS + SUM_GROWTH;

    // Clamped geometry
    logic [WCMP-1:0]   fw_ext;
    logic [HCMP-1:0]   fh_ext;
    logic [W_BITS-1:0] w_eff;
    logic [H_BITS-1:0] h_eff;

    // Position of the next pixel
    logic [COL_BITS-1:0] col_count_reg, col_count_next;
    logic [ROW_BITS-1:0] row_count_reg, row_count_next;
    logic [COL_BITS-1:0] c_cur;
    logic [ROW_BITS-1:0] r_cur;
    logic [W_BITS-1:0]   c_plus1;
    logic [H_BITS-1:0]   r_plus1;
    logic                at_last_col;
    logic                at_last_row;
    logic                in_accept;

    // Item under work
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic                  s1_row_ge1_reg, s1_row_ge2_reg;
    logic                  s1_col_ge1_reg, s1_col_ge2_reg;
    logic                  s1_last_col_reg, s1_last_row_reg;
    logic                  s1_retire;

    // Line store access and write-to-read forwarding
    logic [2*PIXEL_BITS-1:0] rd_data_a, rd_data_b;
    logic                    wr_en;
    logic [COL_BITS-1:0]     wr_addr;
    logic [2*PIXEL_BITS-1:0] wr_data;
    logic [COL_BITS-1:0]     rd_addr_b;
    logic                    byp_mid_hit_reg, byp_right_hit_reg;
    logic [2*PIXEL_BITS-1:0] byp_word_reg;
    logic [2*PIXEL_BITS-1:0] word;

    // Neighbors
    logic [PIXEL_BITS-1:0] mid, up2, right;
    logic [PIXEL_BITS-1:0] prev_mid_reg, held_prev_reg, held_prev2_reg;

    // Candidate results
    logic                cand_pres [MAX_RESULTS];
    res_tag_t            cand_tag  [MAX_RESULTS];
    logic [SUM_BITS-1:0] cand_sum  [MAX_RESULTS];
    logic [ROW_BITS-1:0] row_m1;
    logic [COL_BITS-1:0] col_m1;
    logic [RES_COUNT_BITS-1:0] res_k;

    assign fw_ext = WCMP'(frame_width);
    assign fh_ext = HCMP'(frame_height);

    always_comb
    begin
        if (fw_ext == '0)
            w_eff = W_BITS'(1);
        else if (fw_ext > WCMP'(MAX_WIDTH))
            w_eff = W_BITS'(MAX_WIDTH);
        else
            w_eff = W_BITS'(fw_ext);

        if (fh_ext == '0)
            h_eff = H_BITS'(1);
        else if (fh_ext > HCMP'(MAX_HEIGHT))
            h_eff = H_BITS'(MAX_HEIGHT);
        else
            h_eff = H_BITS'(fh_ext);
    end

    // Restart a counter left beyond a shrunken geometry
    assign c_cur = (W_BITS'(col_count_reg) >= w_eff) ? '0 : col_count_reg;
    assign r_cur = (H_BITS'(row_count_reg) >= h_eff) ? '0 : row_count_reg;
    assign c_plus1     = W_BITS'(c_cur) + W_BITS'(1);
    assign r_plus1     = H_BITS'(r_cur) + H_BITS'(1);
    assign at_last_col = (c_plus1 == w_eff);
    assign at_last_row = (r_plus1 == h_eff);

    always_comb
    begin
        if (at_last_col)
        begin
            col_count_next = '0;
            row_count_next = at_last_row ? '0 : ROW_BITS'(r_plus1);
        end
        else
        begin
            col_count_next = COL_BITS'(c_plus1);
            row_count_next = r_cur;
        end
    end

    assign grp_valid = s1_valid_reg && (grp_count != '0);
    assign s1_retire = s1_valid_reg && ((grp_count == '0) || grp_ready);
    assign in_ready  = !s1_valid_reg || s1_retire;
    assign in_accept = in_valid && in_ready;

    assign wr_en     = s1_retire;
    assign wr_addr   = s1_col_reg;
    assign wr_data   = {mid, s1_pixel_reg};
    assign rd_addr_b = COL_BITS'(c_plus1);

    csmf_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (in_accept),
        .rd_addr_a (c_cur),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Low half: previous row; high half: row before that
    assign word  = byp_mid_hit_reg ? byp_word_reg : rd_data_a;
    assign mid   = word[PIXEL_BITS-1:0];
    assign up2   = word[2*PIXEL_BITS-1:PIXEL_BITS];
    assign right = byp_right_hit_reg ? byp_word_reg[PIXEL_BITS-1:0]
                                     : rd_data_b[PIXEL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            s1_valid_reg      <= 1'b0;
            byp_mid_hit_reg   <= 1'b0;
            byp_right_hit_reg <= 1'b0;
            prev_mid_reg      <= '0;
            held_prev_reg     <= '0;
            held_prev2_reg    <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                col_count_reg     <= col_count_next;
                row_count_reg     <= row_count_next;
                byp_mid_hit_reg   <= wr_en && (wr_addr == c_cur);
                byp_right_hit_reg <= wr_en && (wr_addr == rd_addr_b);
            end
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_retire)
                s1_valid_reg <= 1'b0;
            if (s1_retire)
            begin
                prev_mid_reg   <= mid;
                held_prev_reg  <= s1_pixel_reg;
                held_prev2_reg <= held_prev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg    <= PIXEL_BITS'(in_pixel);
            s1_col_reg      <= c_cur;
            s1_row_reg      <= r_cur;
            s1_row_ge1_reg  <= (r_cur != '0);
            s1_row_ge2_reg  <= (H_BITS'(r_cur) >= H_BITS'(2));
            s1_col_ge1_reg  <= (c_cur != '0);
            s1_col_ge2_reg  <= (W_BITS'(c_cur) >= W_BITS'(2));
            s1_last_col_reg <= at_last_col;
            s1_last_row_reg <= at_last_row;
            byp_word_reg    <= wr_data;
        end
    end

    assign row_m1 = s1_row_reg - ROW_BITS'(1);
    assign col_m1 = s1_col_reg - COL_BITS'(1);

    always_comb
    begin
        // Up position, completed by its down neighbor
        cand_pres[0] = s1_row_ge1_reg;
        cand_sum[0]  = SUM_BITS'(mid) + SUM_BITS'(s1_pixel_reg)
                     + (s1_row_ge2_reg   ? SUM_BITS'(up2)          : '0)
                     + (s1_col_ge1_reg   ? SUM_BITS'(prev_mid_reg) : '0)
                     + (!s1_last_col_reg ? SUM_BITS'(right)        : '0);
        cand_tag[0].row = ROW_FIELD_BITS'(row_m1);
        cand_tag[0].col = COL_FIELD_BITS'(s1_col_reg);
        cand_tag[0].cnt = CNT_BITS'(2) + CNT_BITS'(s1_row_ge2_reg)
                        + CNT_BITS'(s1_col_ge1_reg) + CNT_BITS'(!s1_last_col_reg);
        cand_tag[0].frame_done = 1'b0;

        // Last row: left position, completed by its right neighbor
        cand_pres[1] = s1_last_row_reg && s1_col_ge1_reg;
        cand_sum[1]  = SUM_BITS'(held_prev_reg) + SUM_BITS'(s1_pixel_reg)
                     + (s1_row_ge1_reg ? SUM_BITS'(prev_mid_reg)   : '0)
                     + (s1_col_ge2_reg ? SUM_BITS'(held_prev2_reg) : '0);
        cand_tag[1].row = ROW_FIELD_BITS'(s1_row_reg);
        cand_tag[1].col = COL_FIELD_BITS'(col_m1);
        cand_tag[1].cnt = CNT_BITS'(2) + CNT_BITS'(s1_row_ge1_reg)
                        + CNT_BITS'(s1_col_ge2_reg);
        cand_tag[1].frame_done = 1'b0;

        // Final pixel of the frame: its own position
        cand_pres[2] = s1_last_row_reg && s1_last_col_reg;
        cand_sum[2]  = SUM_BITS'(s1_pixel_reg)
                     + (s1_row_ge1_reg ? SUM_BITS'(mid)           : '0)
                     + (s1_col_ge1_reg ? SUM_BITS'(held_prev_reg) : '0);
        cand_tag[2].row = ROW_FIELD_BITS'(s1_row_reg);
        cand_tag[2].col = COL_FIELD_BITS'(s1_col_reg);
        cand_tag[2].cnt = CNT_BITS'(1) + CNT_BITS'(s1_row_ge1_reg)
                        + CNT_BITS'(s1_col_ge1_reg);
        cand_tag[2].frame_done = 1'b1;

        cand_tag[2].run_last = cand_pres[2];
        cand_tag[1].run_last = cand_pres[1] && !cand_pres[2];
        cand_tag[0].run_last = cand_pres[0] && !cand_pres[1] && !cand_pres[2];
    end

    // Pack the present results to the low slots, in order
    always_comb
    begin
        res_k = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            grp_tag[i] = '0;
            grp_sum[i] = '0;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (cand_pres[i])
            begin
                grp_tag[res_k] = cand_tag[i];
                grp_sum[res_k] = cand_sum[i];
                res_k = res_k + RES_COUNT_BITS'(1);
            end
        end
        grp_count = res_k;
    end

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_retire |=>
            s1_valid_reg && $stable(s1_col_reg) && $stable(s1_row_reg))
        else $error("item under work changed while stalled");

    a_three_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (grp_count == RES_COUNT_BITS'(MAX_RESULTS)) |->
            s1_last_row_reg && s1_last_col_reg)
        else $error("three results away from the frame end");

    a_one_write_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !wr_en || $past(in_accept))
        else $error("line store written twice for one item");
`endif

endmodule

@@ hw/rtl/csmf_mean_out.sv @@
module csmf_mean_out #(
    parameter int PIXEL_BITS = csmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       grp_valid,
    output logic                                       grp_ready,
    input  logic [csmf_pkg::RES_COUNT_BITS-1:0]        grp_count,
    input  csmf_pkg::res_tag_t                         grp_tag [csmf_pkg::MAX_RESULTS],
    input  logic [PIXEL_BITS+csmf_pkg::SUM_GROWTH-1:0] grp_sum [csmf_pkg::MAX_RESULTS],
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [csmf_pkg::MEAN_BITS-1:0]             out_mean,
    output csmf_pkg::res_tag_t                         out_tag
);

    import csmf_pkg::*;

    localparam int SUM_BITS = PIXEL_BITS + SUM_GROWTH;
    localparam int QD_BITS  = SUM_BITS + CNT_BITS;
    localparam logic [SUM_BITS-1:0] RECIP_3 = SUM_BITS'((longint'(1) << SUM_BITS) / 3);
    localparam logic [SUM_BITS-1:0] RECIP_5 = SUM_BITS'((longint'(1) << SUM_BITS) / 5);

    logic [RES_COUNT_BITS-1:0] slot_cnt_reg;
    res_tag_t                  slot_tag_reg [MAX_RESULTS];
    logic [SUM_BITS-1:0]       slot_sum_reg [MAX_RESULTS];
    logic                      move;
    logic                      load;

    logic                   out_valid_reg;
    logic [MEAN_BITS-1:0]   out_mean_reg;
    res_tag_t               out_tag_reg;

    // Divider for the head slot
    logic [SUM_BITS-1:0]   sum;
    logic [CNT_BITS-1:0]   d;
    logic [SUM_BITS-1:0]   recip_sel;
    logic [2*SUM_BITS-1:0] prod;
    logic [SUM_BITS-1:0]   q_recip;
    logic [SUM_BITS-1:0]   q_est;
    logic [QD_BITS-1:0]    qd;
    logic [SUM_BITS-1:0]   rem_full;
    logic [SUM_BITS-1:0]   q_fix;
    logic [SUM_BITS-1:0]   rem_fix;
    logic [CNT_BITS-1:0]   rem;
    logic [MEAN_BITS-1:0]  mean_calc;

    assign move      = (slot_cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign grp_ready = (slot_cnt_reg == '0)
                    || ((slot_cnt_reg == RES_COUNT_BITS'(1)) && move);
    assign load      = grp_valid && grp_ready;

    assign sum       = slot_sum_reg[0];
    assign d         = slot_tag_reg[0].cnt;
    assign recip_sel = (d == CNT_BITS'(5)) ? RECIP_5 : RECIP_3;
    assign prod      = (2*SUM_BITS)'(sum) * (2*SUM_BITS)'(recip_sel);
    assign q_recip   = prod[2*SUM_BITS-1:SUM_BITS];

    always_comb
    begin
        case (d)
            3'd2:    q_est = sum >> 1;
            3'd3:    q_est = q_recip;
            3'd4:    q_est = sum >> 2;
            3'd5:    q_est = q_recip;
            default: q_est = sum;
        endcase

        case (d)
            3'd2:    qd = QD_BITS'(q_est) << 1;
            3'd3:    qd = (QD_BITS'(q_est) << 1) + QD_BITS'(q_est);
            3'd4:    qd = QD_BITS'(q_est) << 2;
            3'd5:    qd = (QD_BITS'(q_est) << 2) + QD_BITS'(q_est);
            default: qd = QD_BITS'(q_est);
        endcase

        rem_full = sum - SUM_BITS'(qd);

        // Reciprocal estimate may fall one short
        if (rem_full >= SUM_BITS'(d))
        begin
            q_fix   = q_est + SUM_BITS'(1);
            rem_fix = rem_full - SUM_BITS'(d);
        end
        else
        begin
            q_fix   = q_est;
            rem_fix = rem_full;
        end

        rem       = rem_fix[CNT_BITS-1:0];
        mean_calc = MEAN_BITS'({q_fix, frac_lookup(d, rem)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                slot_cnt_reg <= grp_count;
            else if (move)
                slot_cnt_reg <= slot_cnt_reg - RES_COUNT_BITS'(1);

            if (move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_tag_reg[i] <= grp_tag[i];
                slot_sum_reg[i] <= grp_sum[i];
            end
        end
        else if (move)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_tag_reg[i] <= slot_tag_reg[i+1];
                slot_sum_reg[i] <= slot_sum_reg[i+1];
            end
        end

        if (move)
        begin
            out_mean_reg <= mean_calc;
            out_tag_reg  <= slot_tag_reg[0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mean  = out_mean_reg;
    assign out_tag   = out_tag_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        slot_cnt_reg != '0 |-> rem < d)
        else $error("division remainder not below divisor");

    a_move_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("result moved out but not presented");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> slot_cnt_reg == $past(grp_count))
        else $error("slot count does not follow the loaded group");
`endif

endmodule

@@ hw/rtl/cross_stencil_mean_filter_top.sv @@
// Five-point cross mean filter over a raster-order pixel stream.
// Input channel s_axis: one pixel per item, rows in order, left to right.
// Output channel m_axis: one mean per item, tagged with its row and column;
//   tlast marks the last result caused by one input item, tuser[0] the
//   final result of a frame.
// APB port: frame_width at 0x0, frame_height at 0x4; write only while idle.
// The result for (r,c) leaves once pixel (r+1,c) has come in; on the last row
// a result leaves once its right neighbor has come in. Row 0 gives nothing
// unless the frame is a single row.
// Results of an item pass the item register, the queue slots and the output
// register, one per cycle while the output is not stalled. Throughput: 1 item
// per cycle on all rows but the last, with the output not stalled; an item
// with several results holds the next one back while the single divider
// feeds the output register one result per cycle.
// Reset: position counters and pipeline clear; line stores are not cleared
// and need no clearing pass, since the first row fills them before any read
// enters a mean.
// Stall: a stalled output holds its result and the queue holds its sums;
// s_axis_tready drops in the same cycle once an item with results cannot
// pass into the queue. Items that release nothing keep flowing.
module cross_stencil_mean_filter_top #(
    parameter int MAX_WIDTH  = csmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csmf_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = csmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [csmf_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [csmf_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [csmf_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready,
    // Pixel input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [csmf_pkg::PIXEL_FIELD_BITS-1:0] s_axis_tdata,  // [15:0] pixel
    // Mean output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [23:0] mean_value, [35:24] out_row, [45:36] out_col, [47:46] zero
    output logic [csmf_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic [0:0]                            m_axis_tuser,  // [0] frame_done
    output logic                                  m_axis_tlast   // run_last
);

    import csmf_pkg::*;

    logic [FRAME_WIDTH_BITS-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_BITS-1:0] frame_height_reg;
    reg_index_t                   reg_index;
    logic                         cfg_write;

    // Hand-off from the stencil stage to the divider queue
    logic                      grp_valid;
    logic                      grp_ready;
    logic [RES_COUNT_BITS-1:0] grp_count;
    res_tag_t                  grp_tag [MAX_RESULTS];
    logic [PIXEL_BITS+SUM_GROWTH-1:0] grp_sum [MAX_RESULTS];

    logic [MEAN_BITS-1:0] out_mean;
    res_tag_t             out_tag;

    // Decode the register by its word address; byte offset bits are ignored
    assign reg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Counters, line stores, neighbor window and the sums of each result
    csmf_stencil #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_stencil (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_pixel     (s_axis_tdata),
        .grp_valid    (grp_valid),
        .grp_ready    (grp_ready),
        .grp_count    (grp_count),
        .grp_tag      (grp_tag),
        .grp_sum      (grp_sum)
    );

    // Queue of up to three pending sums, divider, output register
    csmf_mean_out #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mean_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp_count (grp_count),
        .grp_tag   (grp_tag),
        .grp_sum   (grp_sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_mean  (out_mean),
        .out_tag   (out_tag)
    );

    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_tag.col, out_tag.row, out_mean};
    assign m_axis_tuser = out_tag.frame_done;
    assign m_axis_tlast = out_tag.run_last;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import csmf_pkg::*;

    // Clock, reset and block ports. Every input starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]    paddr = '0;
    logic [CFG_DATA_BITS-1:0]    pwdata = '0;
    logic [CFG_DATA_BITS-1:0]    prdata;
    logic                        pready;

    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [PIXEL_FIELD_BITS-1:0] s_axis_tdata = '0;   // [15:0] pixel

    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;        // [23:0] mean, [35:24] row, [45:36] col
    logic [0:0]                  m_axis_tuser;        // [0] frame_done
    logic                        m_axis_tlast;        // run_last

    // Layout of m_axis_tdata, lowest field last
    typedef struct packed
    {
        logic [OUT_PAD_BITS-1:0]   pad;
        logic [COL_FIELD_BITS-1:0] col;
        logic [ROW_FIELD_BITS-1:0] row;
        logic [MEAN_BITS-1:0]      mean;
    } mean_word_t;

    // One expected filter output
    typedef struct packed
    {
        logic [MEAN_BITS-1:0]      mean;
        logic [ROW_FIELD_BITS-1:0] row;
        logic [COL_FIELD_BITS-1:0] col;
        logic                      frame_done;
        logic                      run_last;
    } filter_result_t;

    cross_stencil_mean_filter_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Filter predictor state: its own line stores, position and geometry
    // ------------------------------------------------------------------
    logic [PIXEL_FIELD_BITS-1:0]  above_row [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIXEL_FIELD_BITS-1:0]  older_row [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIXEL_FIELD_BITS-1:0]  prev_pix = '0;
    logic [PIXEL_FIELD_BITS-1:0]  prev2_pix = '0;
    int unsigned                  next_row = 0;
    int unsigned                  next_col = 0;
    logic [FRAME_WIDTH_BITS-1:0]  cfg_width = FRAME_WIDTH_RESET;
    logic [FRAME_HEIGHT_BITS-1:0] cfg_height = FRAME_HEIGHT_RESET;

    filter_result_t              mean_queue [$];   // means still owed by the block
    logic [PIXEL_FIELD_BITS-1:0] pix_queue [$];    // pixels not yet driven

    int unsigned pix_pushed = 0;     // pixels handed to the driver
    int unsigned pix_sent = 0;       // pixels taken by the block
    int unsigned error_count = 0;
    int unsigned clean_width = 0;    // columns whose line store entries hold real pixels
    int unsigned pix_gap = 0;
    int unsigned mean_stall = 0;
    bit          pix_taken = 1'b0;
    bit          idle_on = 1'b1;

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic filter_result_t mean_of(input int unsigned sum, cnt, row, col);
        filter_result_t res;
        res.mean       = MEAN_BITS'(((sum << FRAC_BITS) + cnt / 2) / cnt);
        res.row        = ROW_FIELD_BITS'(row);
        res.col        = COL_FIELD_BITS'(col);
        res.frame_done = 1'b0;
        res.run_last   = 1'b0;
        return res;
    endfunction

    // Advance the filter by one pixel and queue the means it releases
    function automatic void predict_means(input logic [PIXEL_FIELD_BITS-1:0] pix);
        int unsigned    w, h, r, c, mid, up2, lft, rgt, sum, cnt, n;
        filter_result_t outs [MAX_RESULTS];
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        // A geometry change can leave the position outside the new frame
        if (next_col >= w)
            next_col = 0;
        if (next_row >= h)
            next_row = 0;
        r   = next_row;
        c   = next_col;
        n   = 0;
        mid = above_row[c];
        up2 = older_row[c];
        lft = 0;
        rgt = 0;
        if (c > 0)
            lft = older_row[c - 1];
        if (c + 1 < w)
            rgt = above_row[c + 1];

        // Position above is now complete: its lower neighbor just came in
        if (r >= 1)
        begin
            sum = mid + pix;
            cnt = 2;
            if (r >= 2)
            begin
                sum += up2;
                cnt++;
            end
            if (c > 0)
            begin
                sum += lft;
                cnt++;
            end
            if (c + 1 < w)
            begin
                sum += rgt;
                cnt++;
            end
            outs[n] = mean_of(sum, cnt, r - 1, c);
            n++;
        end
        // Bottom row: the left position is complete once its right neighbor is here
        if (r == h - 1 && c >= 1)
        begin
            sum = prev_pix + pix;
            cnt = 2;
            if (r > 0)
            begin
                sum += lft;
                cnt++;
            end
            if (c >= 2)
            begin
                sum += prev2_pix;
                cnt++;
            end
            outs[n] = mean_of(sum, cnt, r, c - 1);
            n++;
        end
        // Last pixel of the frame closes its own position
        if (r == h - 1 && c == w - 1)
        begin
            sum = pix;
            cnt = 1;
            if (r > 0)
            begin
                sum += mid;
                cnt++;
            end
            if (c > 0)
            begin
                sum += prev_pix;
                cnt++;
            end
            outs[n] = mean_of(sum, cnt, r, c);
            outs[n].frame_done = 1'b1;
            n++;
        end
        if (n > 0)
            outs[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            mean_queue.push_back(outs[i]);

        older_row[c] = mid;
        above_row[c] = pix;
        prev2_pix    = prev_pix;
        prev_pix     = pix;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ports
        logic                        nxt_valid;
        logic [PIXEL_FIELD_BITS-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        // Hold the current item until it is taken
        if (!s_axis_tvalid || pix_taken)
        begin
            nxt_valid = 1'b0;
            if (pix_gap != 0)
                pix_gap--;
            else if (pix_queue.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_data  = pix_queue.pop_front();
                // Schedule a burst of idle cycles after this item now and then
                if (idle_on && $urandom_range(0, 5) == 0)
                    pix_gap = $urandom_range(1, 8);
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;

        // Stall the output side in bursts as well
        if (mean_stall != 0)
        begin
            mean_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
                mean_stall = $urandom_range(1, 8);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        mean_word_t     got;
        filter_result_t want;
        if (rst_n)
        begin
            pix_taken = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = mean_word_t'(m_axis_tdata);
                if (mean_queue.size() == 0)
                    flag_error($sformatf("unexpected mean %h at (%0d,%0d)",
                                         got.mean, got.row, got.col));
                else
                begin
                    want = mean_queue.pop_front();
                    if (got.mean != want.mean)
                        flag_error($sformatf("(%0d,%0d) mean %h, want %h",
                                             want.row, want.col, got.mean, want.mean));
                    if (got.row != want.row)
                        flag_error($sformatf("(%0d,%0d) row %0d", want.row, want.col, got.row));
                    if (got.col != want.col)
                        flag_error($sformatf("(%0d,%0d) col %0d", want.row, want.col, got.col));
                    if (m_axis_tuser[0] != want.frame_done)
                        flag_error($sformatf("(%0d,%0d) frame_done %b",
                                             want.row, want.col, m_axis_tuser[0]));
                    if (m_axis_tlast != want.run_last)
                        flag_error($sformatf("(%0d,%0d) run_last %b",
                                             want.row, want.col, m_axis_tlast));
                end
            end
            if (pix_taken)
            begin
                predict_means(s_axis_tdata);
                pix_sent++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; they run between rising edges, away from the driver
    // ------------------------------------------------------------------
    task automatic queue_pixel(input logic [PIXEL_FIELD_BITS-1:0] v);
        pix_queue.push_back(v);
        pix_pushed++;
    endtask

    function automatic logic [PIXEL_FIELD_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_FIELD_BITS'($urandom);
        endcase
    endfunction

    // Wait until every pixel is taken and every mean has come, then let the
    // pipeline empty out behind pixels that release no mean.
    task automatic settle();
        do
            @(negedge clk);
        while (pix_sent != pix_pushed || mean_queue.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // rising edge inside the access cycle.
    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            cfg_width = value[FRAME_WIDTH_BITS-1:0];
        else
            cfg_height = value[FRAME_HEIGHT_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned w_raw, input int unsigned h_raw);
        settle();
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
    endtask

    // Whole frames of random pixels at a new geometry
    task automatic fill_frames(input int unsigned w_raw, input int unsigned h_raw,
                               input int unsigned frames);
        int unsigned w, h, r, c, remain;
        settle();
        // Close a frame left open by a mid-frame geometry change first, so the
        // new geometry starts at the top-left corner.
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        r = (next_row >= h) ? 0 : next_row;
        c = (next_col >= w) ? 0 : next_col;
        remain = (r == 0 && c == 0) ? 0 : (h - r) * w - c;
        repeat (remain) queue_pixel(rand_pixel());

        configure(w_raw, h_raw);
        w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
        repeat (frames * w * h) queue_pixel(rand_pixel());
        // Two full rows leave both line stores written across the width
        if (h >= 2 && w > clean_width)
            clean_width = w;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned rand_start, cut_w;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // 3x3 frame: corner, edge and center divisors, three means on the
        // last pixel, rounding of sums that do not divide evenly.
        configure(3, 3);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h0000);
        queue_pixel(16'h0001);
        queue_pixel(16'h8000);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h7FFF);
        queue_pixel(16'h0000);
        queue_pixel(16'hFFFE);
        queue_pixel(16'hFFFF);
        clean_width = 3;

        // Width 0 acts as 1: a single column
        configure(0, 4);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h0000);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h0001);

        // One-pixel frame: divisor 1, largest mean
        configure(1, 1);
        queue_pixel(16'hFFFF);

        // Single row: only left and right neighbors count
        configure(5, 1);
        queue_pixel(16'h0000);
        queue_pixel(16'hFFFF);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h0000);
        queue_pixel(16'hAAAA);

        configure(2, 2);
        queue_pixel(16'h0001);
        queue_pixel(16'h0002);
        queue_pixel(16'h5555);
        queue_pixel(16'hFFFF);

        // Oversized registers act as the maximum; a width of 1025 and a
        // height of 4097 would act as 1 if their top bits were dropped.
        configure(1025, 1);
        repeat (12) queue_pixel(rand_pixel());
        // Narrow the frame mid-row: the column restarts at 0 of the same row
        configure(3, 4097);
        repeat (12) queue_pixel(rand_pixel());
        // Drop the height below the current row: the next pixel starts a frame
        configure(3, 4);

        // Random geometries. Most phases are whole frames; the rest change
        // the geometry mid-frame, kept within columns already written.
        rand_start = pix_pushed;
        while (pix_pushed - rand_start < 340)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                cut_w = $urandom_range(0, (clean_width < 12) ? clean_width : 12);
                configure(cut_w, $urandom_range(0, 8));
                repeat ($urandom_range(1, 40)) queue_pixel(rand_pixel());
            end
            else
                fill_frames($urandom_range(0, 12), $urandom_range(0, 8),
                            $urandom_range(1, 2));
        end

        // Closing stretch at full rate on both sides
        idle_on = 1'b0;
        fill_frames(6, 4, 1);
        settle();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Bound the run far above the slowest correct one
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
